/* sv/rhsv_pkg.sv */
// Package for the RGB to HSV pixel core: item types, constants, sector codes.
`default_nettype none
package rhsv_pkg;

  // Fixed-point constants, hue in 1/64 degree
  localparam int HueSixty  = 3840;    // 60 degrees
  localparam int HueTurn   = 23040;   // 360 degrees
  localparam int OffGreen  = 7680;    // 120 degrees
  localparam int OffBlue   = 15360;   // 240 degrees
  localparam int SatScale2 = 131070;  // 2 * 65535

  // Divider geometry
  localparam int QuotW      = 16;                       // quotient bits
  localparam int StepsPerSt = 4;                        // quotient bits per stage
  localparam int DivStages  = QuotW / StepsPerSt;       // divider stages
  localparam int RemW       = 9;                        // divisor / remainder width
  localparam int PipeDepth  = 3 + DivStages;            // total register stages

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_e;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [31:0] coord_x;
    logic [31:0] coord_y;
    logic [31:0] coord_z;
  } hsv_in_t;

  typedef struct packed {
    logic [14:0] hue;
    logic [15:0] saturation;
    logic [15:0] brightness;
    logic [31:0] out_x;
    logic [31:0] out_y;
    logic [31:0] out_z;
  } hsv_out_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } coord_t;

  // One long-division lane: remainder, dividend bits shifting out at the top
  // while quotient bits shift in at the bottom, and the divisor.
  typedef struct packed {
    logic [RemW-1:0]  rem;
    logic [QuotW-1:0] bits;
    logic [RemW-1:0]  dvs;
  } div_lane_t;

  // Side data that rides along the divider stages
  typedef struct packed {
    logic [7:0] mx;
    logic       hue_zero;
    logic       sat_zero;
    coord_t     crd;
  } div_meta_t;

endpackage
`default_nettype wire

/* sv/rgb_to_hsv_pixel_core.sv */
// RGB to HSV pixel core: pipelined fixed-point conversion with coordinate pass-through.
`default_nettype none
//
//  Channel | Direction | Handshake                 | Payload
//  --------+-----------+---------------------------+-----------------------------
//  input   | in        | in_valid_i / in_stall_o   | in_data_i  (hsv_in_t)
//  output  | out       | out_valid_o / out_stall_i | out_data_o (hsv_out_t)
//
//  Seven register stages, with one item per cycle sustained for as long as no stalled
//  result holds the output.
//  Stages: min/max and sector, hue/sat numerators, hue wrap, then four stages of a
//  restoring divider that resolve 4 quotient bits each for both divisions.
//  Reset clears only the per-stage valid bits; payload registers are not reset.
//  A stalled result on the output freezes the whole pipe, and in_stall_o follows it,
//  so no item is dropped or repeated.
//
module rgb_to_hsv_pixel_core
  import rhsv_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire hsv_in_t  in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output hsv_out_t      out_data_o
);

  // Four restoring division steps on one lane.
  function automatic div_lane_t div_step(div_lane_t l);
    div_lane_t     o;
    logic [RemW:0] t;
    o = l;
    for (int i = 0; i < StepsPerSt; i++) begin
      t = {o.rem, o.bits[QuotW-1]};
      if (t >= {1'b0, o.dvs}) begin
        t      = t - {1'b0, o.dvs};
        o.bits = {o.bits[QuotW-2:0], 1'b1};
      end else begin
        o.bits = {o.bits[QuotW-2:0], 1'b0};
      end
      o.rem = t[RemW-1:0];
    end
    return o;
  endfunction

  // Pipe advances unless the output holds an item that is stalled.
  logic adv;
  logic [PipeDepth-1:0] v_q;

  assign adv        = !(v_q[PipeDepth-1] && out_stall_i);
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[PipeDepth-2:0], in_valid_i};
    end
  end

  // ---------------- Stage 1: max, min, sector, hue numerator term
  logic [7:0]        s1_mx_d, s1_mn_d, s1_mx_q, s1_d_q;
  logic signed [8:0] s1_num_d, s1_num_q;
  sector_e           s1_sec_d, s1_sec_q;
  coord_t            s1_crd_q;

  always_comb begin
    s1_mx_d = in_data_i.red;
    s1_mn_d = in_data_i.red;
    if (in_data_i.green > s1_mx_d) s1_mx_d = in_data_i.green;
    if (in_data_i.blue  > s1_mx_d) s1_mx_d = in_data_i.blue;
    if (in_data_i.green < s1_mn_d) s1_mn_d = in_data_i.green;
    if (in_data_i.blue  < s1_mn_d) s1_mn_d = in_data_i.blue;
    // red wins ties over green, green over blue
    if (s1_mx_d == in_data_i.red) begin
      s1_sec_d = SEC_RED;
      s1_num_d = $signed({1'b0, in_data_i.green}) - $signed({1'b0, in_data_i.blue});
    end else if (s1_mx_d == in_data_i.green) begin
      s1_sec_d = SEC_GREEN;
      s1_num_d = $signed({1'b0, in_data_i.blue}) - $signed({1'b0, in_data_i.red});
    end else begin
      s1_sec_d = SEC_BLUE;
      s1_num_d = $signed({1'b0, in_data_i.red}) - $signed({1'b0, in_data_i.green});
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_mx_q  <= s1_mx_d;
      s1_d_q   <= s1_mx_d - s1_mn_d;
      s1_num_q <= s1_num_d;
      s1_sec_q <= s1_sec_d;
      s1_crd_q <= '{x: in_data_i.coord_x, y: in_data_i.coord_y, z: in_data_i.coord_z};
    end
  end

  // ---------------- Stage 2: raw hue numerator and saturation dividend
  logic signed [23:0] s2_n_d, s2_n_q, num_ext;
  logic [23:0]        off_term;
  logic [24:0]        s2_sat_d, s2_sat_q;
  logic [7:0]         s2_mx_q, s2_d_q;
  coord_t             s2_crd_q;

  always_comb begin
    num_ext = 24'(s1_num_q);
    case (s1_sec_q)
      SEC_RED:   off_term = '0;
      SEC_GREEN: off_term = 24'(s1_d_q) * 24'(OffGreen);
      SEC_BLUE:  off_term = 24'(s1_d_q) * 24'(OffBlue);
      default:   off_term = '0;
    endcase
    s2_n_d   = num_ext * 24'(HueSixty) + $signed(off_term);
    // 2*65535*d + mx, for round(65535*d/mx) = floor(that / (2*mx))
    s2_sat_d = 25'(s1_d_q) * 25'(SatScale2) + 25'(s1_mx_q);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_n_q   <= s2_n_d;
      s2_sat_q <= s2_sat_d;
      s2_mx_q  <= s1_mx_q;
      s2_d_q   <= s1_d_q;
      s2_crd_q <= s1_crd_q;
    end
  end

  // ---------------- Stage 3: wrap negative hue, load divider lanes
  logic signed [23:0] n_fix;
  logic [23:0]        hue_num;
  div_lane_t          dv_sat_q [DivStages+1];
  div_lane_t          dv_hue_q [DivStages+1];
  div_meta_t          dv_meta_q [DivStages+1];

  always_comb begin
    if (s2_n_q < 0) begin
      n_fix = s2_n_q + $signed(24'(s2_d_q) * 24'(HueTurn));
    end else begin
      n_fix = s2_n_q;
    end
    hue_num = {n_fix[22:0], 1'b0} + 24'(s2_d_q);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv_sat_q[0]  <= '{rem: s2_sat_q[24:QuotW], bits: s2_sat_q[QuotW-1:0],
                        dvs: {s2_mx_q, 1'b0}};
      dv_hue_q[0]  <= '{rem: RemW'(hue_num[23:QuotW]), bits: hue_num[QuotW-1:0],
                        dvs: {s2_d_q, 1'b0}};
      dv_meta_q[0] <= '{mx: s2_mx_q, hue_zero: (s2_d_q == '0),
                        sat_zero: (s2_mx_q == '0), crd: s2_crd_q};
    end
  end

  // ---------------- Divider stages: 4 quotient bits per stage on both lanes
  for (genvar k = 0; k < DivStages; k++) begin : g_div
    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_sat_q[k+1]  <= div_step(dv_sat_q[k]);
        dv_hue_q[k+1]  <= div_step(dv_hue_q[k]);
        dv_meta_q[k+1] <= dv_meta_q[k];
      end
    end
  end

  // ---------------- Output: zero hue for grey, zero saturation for black
  div_meta_t m_last;
  assign m_last      = dv_meta_q[DivStages];
  assign out_valid_o = v_q[PipeDepth-1];

  always_comb begin
    out_data_o.hue        = m_last.hue_zero ? '0 : dv_hue_q[DivStages].bits[14:0];
    out_data_o.saturation = m_last.sat_zero ? '0 : dv_sat_q[DivStages].bits;
    out_data_o.brightness = {m_last.mx, m_last.mx};
    out_data_o.out_x      = m_last.crd.x;
    out_data_o.out_y      = m_last.crd.y;
    out_data_o.out_z      = m_last.crd.z;
  end

endmodule
`default_nettype wire
